@@ src/hpdt_pkg.sv @@
// Shared constants, types and hash constants for the packet deduplication table.
`default_nettype none

package hpdt_pkg;

	// Table geometry. BUCKETS is a power of two, so the bucket is the low hash bits.
	localparam int BUCKETS  = 1024;
	localparam int WAYS     = 4;
	localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int KEY_W    = 32;
	localparam int UNIQUE_W = 13;
	localparam int CNT_W    = 64;

	// Mixer constants.
	localparam logic [KEY_W-1:0] MIX_MUL1 = 32'h7feb352d;
	localparam logic [KEY_W-1:0] MIX_MUL2 = 32'h846ca68b;
	localparam logic [KEY_W-1:0] EVT_SALT = 32'h9e3779b9;
	localparam logic [KEY_W-1:0] VTX_OFS  = 32'd17;
	localparam logic [KEY_W-1:0] EVT_OFS  = 32'd31;

	// Number of independent mixer lanes in the hash unit.
	localparam int LANES = 5;

	// Operation field of a request transaction.
	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_CLEAR  = 1'b1
	} dedup_op_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] vertex;
		logic [KEY_W-1:0] evt;
		logic [KEY_W-1:0] word;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic s1_en;
		logic s2_en;
	} hash_ctl_t;

endpackage

`default_nettype wire

@@ src/hpdt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module hpdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ src/hpdt_hash.sv @@
// Two-stage multiply/xorshift hash unit producing the key hash and the entry word.
`default_nettype none

module hpdt_hash
	import hpdt_pkg::*;
(
	input  wire logic             clk,
	input  wire hash_ctl_t        ctl,
	input  wire logic [KEY_W-1:0] key_v,
	input  wire logic [KEY_W-1:0] key_e,
	input  wire logic [KEY_W-1:0] key_t,
	output      logic [KEY_W-1:0] hash,
	output      logic [KEY_W-1:0] word
);

	logic [KEY_W-1:0] lane_in [LANES];
	logic [KEY_W-1:0] prod_s1 [LANES];
	logic [KEY_W-1:0] prod_s2 [LANES];
	logic [KEY_W-1:0] lane_out [LANES];

	// Lanes: vertex, salted event, timestamp, and the two offsets for the entry word.
	always_comb begin
		lane_in[0] = key_v;
		lane_in[1] = key_e + EVT_SALT;
		lane_in[2] = key_t;
		lane_in[3] = key_v + VTX_OFS;
		lane_in[4] = key_e + EVT_OFS;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (ctl.s1_en) begin
				prod_s1[i] <= (lane_in[i] ^ (lane_in[i] >> 16)) * MIX_MUL1;
			end
			if (ctl.s2_en) begin
				prod_s2[i] <= (prod_s1[i] ^ (prod_s1[i] >> 15)) * MIX_MUL2;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_out[i] = prod_s2[i] ^ (prod_s2[i] >> 16);
		end
		hash = lane_out[0] ^ lane_out[1] ^ lane_out[2];
		word = hash ^ lane_out[3] ^ lane_out[4];
	end

endmodule

`default_nettype wire

@@ src/hashed_packet_dedup_table.sv @@
// Top level of the hashed packet deduplication table: sequencer, bucket update and counters.
`default_nettype none

// A lookup transaction hashes (vertex, event, timestamp), reads the whole bucket row from one
// RAM and either reports a hit, inserts into the lowest free way, or reports the bucket full.
// A lookup passes through the two registered multiplier stages of the hash unit, the registered
// bucket RAM read, and the compare and write-back state; the next transaction is accepted in
// that last state when the output register is free, so lookups do not overlap in the hash unit. A
// clear transaction writes every bucket row of the RAM, one row a cycle, and then returns its result.
// After reset the same clearing pass runs without a result, and no transaction is accepted until
// it ends. A result waiting in the output register stalls the last state of a lookup or a clear,
// and acceptance with it; in idle it does not block acceptance of the next transaction.
module hashed_packet_dedup_table
	import hpdt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_ready,
	input  wire logic                operation,
	input  wire logic [KEY_W-1:0]    vertex_id,
	input  wire logic [KEY_W-1:0]    event_index,
	input  wire logic [KEY_W-1:0]    time_stamp,
	output      logic                rsp_valid,
	input  wire logic                rsp_ready,
	output      logic                hit,
	output      logic                inserted,
	output      logic                bucket_full,
	output      logic [KEY_W-1:0]    entry_word,
	output      logic [UNIQUE_W-1:0] unique_total,
	output      logic [CNT_W-1:0]    hit_total,
	output      logic [CNT_W-1:0]    running_checksum
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MIX1   = 6'b000010,
		ST_MIX2   = 6'b000100,
		ST_MIX3   = 6'b001000,
		ST_LOOKUP = 6'b010000,
		ST_SWEEP  = 6'b100000
	} state_t;

	localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(BUCKETS - 1);

	state_t              state_q, state_d;
	logic [BKT_W-1:0]    sweep_cnt_q;
	logic                sweep_reply_q;
	logic                out_valid_q;
	logic                res_hit_q, res_ins_q, res_full_q;
	logic [KEY_W-1:0]    res_word_q;
	logic [UNIQUE_W-1:0] unique_cnt_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    csum_q;

	logic [KEY_W-1:0]    key_v_q, key_e_q, key_t_q;
	logic [KEY_W-1:0]    hash_q, word_q;

	hash_ctl_t           hctl;
	logic [KEY_W-1:0]    hash_c, word_c;

	logic                accept;
	logic                out_free;
	logic                done_lookup, done_clear;

	row_t                row_rd, row_wr;
	logic                ram_wr_en, ram_rd_en;
	logic [BKT_W-1:0]    ram_wr_addr;
	logic [ROW_W-1:0]    ram_rd_data;

	logic                found, have_free;
	logic [WAY_W-1:0]    free_idx;
	logic [KEY_W-1:0]    found_word;
	logic [KEY_W-1:0]    res_word_c;

	assign out_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) || ((state_q == ST_LOOKUP) && out_free);
	assign accept = req_valid && req_ready;

	assign done_lookup = (state_q == ST_LOOKUP) && out_free;
	assign done_clear = (state_q == ST_SWEEP) && sweep_reply_q && (sweep_cnt_q == LAST_ROW) &&
		out_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			key_v_q <= vertex_id;
			key_e_q <= event_index;
			key_t_q <= time_stamp;
		end
	end

	assign hctl.s1_en = (state_q == ST_MIX1);
	assign hctl.s2_en = (state_q == ST_MIX2);

	hpdt_hash u_hash (
		.clk   (clk),
		.ctl   (hctl),
		.key_v (key_v_q),
		.key_e (key_e_q),
		.key_t (key_t_q),
		.hash  (hash_c),
		.word  (word_c)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_MIX3) begin
			hash_q <= hash_c;
			word_q <= word_c;
		end
	end

	assign ram_rd_en = (state_q == ST_MIX3);
	assign row_rd = row_t'(ram_rd_data);

	hpdt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ROW_W'(row_wr)),
		.rd_en   (ram_rd_en),
		.rd_addr (hash_c[BKT_W-1:0]),
		.rd_data (ram_rd_data)
	);

	// First matching way wins; otherwise the lowest-numbered free way is claimed.
	always_comb begin
		found = 1'b0;
		have_free = 1'b0;
		free_idx = '0;
		found_word = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (row_rd[i].valid) begin
				if (!found && row_rd[i].vertex == key_v_q && row_rd[i].evt == key_e_q) begin
					found = 1'b1;
					found_word = row_rd[i].word;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_idx = WAY_W'(i);
			end
		end
	end

	always_comb begin
		if (found) begin
			res_word_c = found_word;
		end else if (have_free) begin
			res_word_c = word_q;
		end else begin
			res_word_c = '0;
		end
	end

	always_comb begin
		row_wr = row_rd;
		ram_wr_en = 1'b0;
		ram_wr_addr = hash_q[BKT_W-1:0];
		if (state_q == ST_SWEEP) begin
			row_wr = '0;
			ram_wr_en = 1'b1;
			ram_wr_addr = sweep_cnt_q;
		end else if (done_lookup && !found && have_free) begin
			row_wr[free_idx].valid = 1'b1;
			row_wr[free_idx].vertex = key_v_q;
			row_wr[free_idx].evt = key_e_q;
			row_wr[free_idx].word = word_q;
			ram_wr_en = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_CLEAR) ? ST_SWEEP : ST_MIX1;
				end
			end
			ST_MIX1: state_d = ST_MIX2;
			ST_MIX2: state_d = ST_MIX3;
			ST_MIX3: state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (accept) begin
					state_d = (operation == OP_CLEAR) ? ST_SWEEP : ST_MIX1;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (sweep_cnt_q == LAST_ROW && (!sweep_reply_q || out_free)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Reset starts a clearing pass that returns no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_cnt_q <= '0;
			sweep_reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_cnt_q <= '0;
				sweep_reply_q <= (operation == OP_CLEAR);
			end else if (state_q == ST_SWEEP && sweep_cnt_q != LAST_ROW) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			unique_cnt_q <= '0;
			hit_cnt_q <= '0;
			csum_q <= '0;
		end else begin
			if (done_lookup || done_clear) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (done_clear) begin
				unique_cnt_q <= '0;
			end else if (done_lookup) begin
				if (found) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end else if (have_free) begin
					unique_cnt_q <= unique_cnt_q + 1'b1;
				end
				if (found || have_free) begin
					csum_q <= csum_q ^ {res_word_c, hash_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_clear) begin
			res_hit_q <= 1'b0;
			res_ins_q <= 1'b0;
			res_full_q <= 1'b0;
			res_word_q <= '0;
		end else if (done_lookup) begin
			res_hit_q <= found;
			res_ins_q <= !found && have_free;
			res_full_q <= !found && !have_free;
			res_word_q <= res_word_c;
		end
	end

	// The counters only change when a new result is loaded, so they drive the outputs directly.
	assign rsp_valid = out_valid_q;
	assign hit = res_hit_q;
	assign inserted = res_ins_q;
	assign bucket_full = res_full_q;
	assign entry_word = res_word_q;
	assign unique_total = unique_cnt_q;
	assign hit_total = hit_cnt_q;
	assign running_checksum = csum_q;

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_LOOKUP || $past(state_q) == ST_SWEEP))
		else $error("result loaded outside the lookup or sweep state");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({res_hit_q, res_ins_q, res_full_q}) <= 1) &&
		(res_hit_q || res_ins_q || res_word_q == '0))
		else $error("inconsistent result flags or entry word");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == ST_LOOKUP || state_q == ST_SWEEP))
		else $error("table written during hashing");

	a_unique_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done_lookup && !found && have_free) |=> unique_cnt_q == $past(unique_cnt_q) + 1'b1)
		else $error("insert did not advance the unique count");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the hashed packet deduplication table.
module tb;
	import hpdt_pkg::*;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int POOL_DEPTH = 64;

	typedef struct {
		bit                hit;
		bit                inserted;
		bit                bucket_full;
		bit [KEY_W-1:0]    entry_word;
		bit [UNIQUE_W-1:0] unique_total;
		bit [CNT_W-1:0]    hit_total;
		bit [CNT_W-1:0]    running_checksum;
	} dedup_result_t;

	typedef struct {
		bit [KEY_W-1:0] vertex;
		bit [KEY_W-1:0] evt;
		bit [KEY_W-1:0] stamp;
	} packet_key_t;

	// Mirrors the bucket table and counters, and queues the response each request should produce.
	class dedup_scoreboard_t;
		bit                slot_valid [BUCKETS*WAYS];
		bit [KEY_W-1:0]    slot_vertex [BUCKETS*WAYS];
		bit [KEY_W-1:0]    slot_evt [BUCKETS*WAYS];
		bit [KEY_W-1:0]    slot_word [BUCKETS*WAYS];
		bit [UNIQUE_W-1:0] entry_count;
		bit [CNT_W-1:0]    hit_count;
		bit [CNT_W-1:0]    checksum;
		dedup_result_t     awaited [$];
		int errors, requests, hits, inserts, fulls, clears;

		function bit [KEY_W-1:0] avalanche(bit [KEY_W-1:0] x);
			x ^= x >> 16;
			x = x * MIX_MUL1;
			x ^= x >> 15;
			x = x * MIX_MUL2;
			x ^= x >> 16;
			return x;
		endfunction

		function bit [KEY_W-1:0] key_hash(bit [KEY_W-1:0] v, bit [KEY_W-1:0] e,
				bit [KEY_W-1:0] t);
			return avalanche(v) ^ avalanche(e + EVT_SALT) ^ avalanche(t);
		endfunction

		function int bucket_of(bit [KEY_W-1:0] v, bit [KEY_W-1:0] e, bit [KEY_W-1:0] t);
			return int'(key_hash(v, e, t) % BUCKETS);
		endfunction

		function void note_request(dedup_op_t op, bit [KEY_W-1:0] v, bit [KEY_W-1:0] e,
				bit [KEY_W-1:0] t);
			dedup_result_t r;
			bit [KEY_W-1:0] h;
			int base;
			int free_slot;
			bit found;
			r.hit = 0;
			r.inserted = 0;
			r.bucket_full = 0;
			r.entry_word = 0;
			requests++;
			if (op == OP_CLEAR) begin
				foreach (slot_valid[i]) slot_valid[i] = 0;
				entry_count = 0;
				clears++;
			end else begin
				h = key_hash(v, e, t);
				base = bucket_of(v, e, t) * WAYS;
				free_slot = -1;
				found = 0;
				for (int w = 0; w < WAYS && !found; w++) begin
					if (slot_valid[base+w]) begin
						if (slot_vertex[base+w] == v && slot_evt[base+w] == e) begin
							found = 1;
							r.entry_word = slot_word[base+w];
						end
					end else if (free_slot < 0) begin
						free_slot = base + w;
					end
				end
				if (found) begin
					r.hit = 1;
					hit_count++;
					checksum ^= {r.entry_word, h};
					hits++;
				end else if (free_slot >= 0) begin
					r.entry_word = h ^ avalanche(v + VTX_OFS) ^ avalanche(e + EVT_OFS);
					slot_valid[free_slot] = 1;
					slot_vertex[free_slot] = v;
					slot_evt[free_slot] = e;
					slot_word[free_slot] = r.entry_word;
					entry_count++;
					checksum ^= {r.entry_word, h};
					r.inserted = 1;
					inserts++;
				end else begin
					r.bucket_full = 1;
					fulls++;
				end
			end
			r.unique_total = entry_count;
			r.hit_total = hit_count;
			r.running_checksum = checksum;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_result(logic h_bit, logic ins_bit, logic full_bit,
				logic [KEY_W-1:0] word, logic [UNIQUE_W-1:0] uniq,
				logic [CNT_W-1:0] hcount, logic [CNT_W-1:0] csum);
			dedup_result_t r;
			if (awaited.size() == 0) begin
				errors++;
				$error("response with no request outstanding");
				return;
			end
			r = awaited.pop_front();
			compare_field("hit", r.hit, h_bit);
			compare_field("inserted", r.inserted, ins_bit);
			compare_field("bucket_full", r.bucket_full, full_bit);
			compare_field("entry_word", r.entry_word, word);
			compare_field("unique_total", r.unique_total, uniq);
			compare_field("hit_total", r.hit_total, hcount);
			compare_field("running_checksum", r.running_checksum, csum);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic                operation;
	logic [KEY_W-1:0]    vertex_id;
	logic [KEY_W-1:0]    event_index;
	logic [KEY_W-1:0]    time_stamp;
	logic                rsp_valid;
	logic                rsp_ready;
	logic                hit;
	logic                inserted;
	logic                bucket_full;
	logic [KEY_W-1:0]    entry_word;
	logic [UNIQUE_W-1:0] unique_total;
	logic [CNT_W-1:0]    hit_total;
	logic [CNT_W-1:0]    running_checksum;

	dedup_scoreboard_t sb;
	packet_key_t     key_pool [$];
	int              hot_bucket [4];
	int              burst_left = 0;
	rx_mode_t        rx_mode = RX_OPEN;
	int              mode_left = 0;
	int              hold_left = 0;
	int              quiet_cycles = 0;

	hashed_packet_dedup_table DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender: bursts of back-to-back requests separated by random gaps.
	task automatic issue(dedup_op_t op, bit [KEY_W-1:0] v, bit [KEY_W-1:0] e,
			bit [KEY_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				operation <= 1'($urandom);
				vertex_id <= $urandom;
				event_index <= $urandom;
				time_stamp <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		operation <= op;
		vertex_id <= v;
		event_index <= e;
		time_stamp <= t;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(op, v, e, t);
	endtask

	task automatic issue_key(packet_key_t k);
		issue(OP_LOOKUP, k.vertex, k.evt, k.stamp);
	endtask

	// Searches for a timestamp that steers the given vertex and event into one bucket.
	function automatic bit [KEY_W-1:0] find_stamp(bit [KEY_W-1:0] v, bit [KEY_W-1:0] e,
			int bucket);
		bit [KEY_W-1:0] t;
		t = $urandom;
		for (int i = 0; i < 30000 && sb.bucket_of(v, e, t) != bucket; i++) t = $urandom;
		return t;
	endfunction

	function automatic bit [KEY_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic void remember_key(packet_key_t k);
		key_pool.push_back(k);
		if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
	endfunction

	task automatic run_directed();
		packet_key_t zero_key, ones_key, k;
		int home;
		zero_key = '{'0, '0, '0};
		ones_key = '{'1, '1, '1};
		home = sb.bucket_of('0, '0, '0);
		// A clear on an empty table, then the all-zero and all-one keys in and back out.
		issue(OP_CLEAR, '1, '1, '1);
		issue_key(zero_key);
		issue_key(zero_key);
		issue_key(ones_key);
		issue_key(ones_key);
		// Same key under another timestamp: a hit when it lands in the same bucket,
		// a second copy when it lands elsewhere.
		k = '{'0, '0, find_stamp('0, '0, home)};
		issue_key(k);
		k = '{'0, '0, find_stamp('0, '0, (home + 1) % BUCKETS)};
		issue_key(k);
		// Fill the home bucket; vertex-only and event-only matches must not hit.
		k = '{32'd0, 32'd1, find_stamp(32'd0, 32'd1, home)};
		issue_key(k);
		issue_key('{32'd1, 32'd0, find_stamp(32'd1, 32'd0, home)});
		issue_key('{32'd5, 32'd5, find_stamp(32'd5, 32'd5, home)});
		issue_key('{32'd7, 32'd7, find_stamp(32'd7, 32'd7, home)});
		issue_key(k);
		issue_key('{32'd5, 32'd5, find_stamp(32'd5, 32'd5, home)});
		issue_key('{32'd9, 32'd9, find_stamp(32'd9, 32'd9, home)});
		issue(OP_CLEAR, '0, '0, '0);
		issue_key(zero_key);
		issue_key(zero_key);
		issue(OP_CLEAR, $urandom, $urandom, $urandom);
	endtask

	task automatic run_random();
		packet_key_t k, old;
		int pick, hb;
		foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(0, BUCKETS - 1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			k = '{pick_word(), pick_word(), $urandom};
			old = (key_pool.size() > 0) ? key_pool[$urandom_range(0, key_pool.size() - 1)] : k;
			if (pick < 2) begin
				issue(OP_CLEAR, $urandom, $urandom, $urandom);
			end else begin
				if (pick < 40 || key_pool.size() == 0) begin
					// fresh key as drawn
				end else if (pick < 62) begin
					k = old;
				end else if (pick < 72) begin
					k.vertex = old.vertex;
					k.evt = old.evt;
					k.stamp = find_stamp(old.vertex, old.evt,
						sb.bucket_of(old.vertex, old.evt, old.stamp));
				end else if (pick < 78) begin
					k.vertex = old.vertex;
					k.evt = old.evt;
				end else if (pick < 92) begin
					// A few hot buckets fill up and then overflow.
					hb = $urandom_range(0, 3);
					if ($urandom_range(0, 29) == 0) hot_bucket[hb] = $urandom_range(0, BUCKETS - 1);
					k.stamp = find_stamp(k.vertex, k.evt, hot_bucket[hb]);
				end else begin
					// Near miss: same vertex, one event bit flipped, same bucket.
					k.vertex = old.vertex;
					k.evt = old.evt ^ (32'd1 << $urandom_range(0, 31));
					k.stamp = find_stamp(k.vertex, k.evt,
						sb.bucket_of(old.vertex, old.evt, old.stamp));
				end
				issue_key(k);
				remember_key(k);
			end
		end
	endtask

	// Receiver: checks every response and backpressures in changing patterns.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_result(hit, inserted, bucket_full, entry_word, unique_total, hit_total,
				running_checksum);
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 160);
		end
		mode_left--;
		case (rx_mode)
			RX_OPEN: rsp_ready <= 1'b1;
			RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rsp_ready <= (mode_left % 4 == 0);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					rsp_ready <= 1'b0;
				end else begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(8, 30);
				end
			end
		endcase
	end

	// A long stretch with no transaction on either side means the block has hung.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		operation <= OP_LOOKUP;
		vertex_id <= '0;
		event_index <= '0;
		time_stamp <= '0;
		rsp_ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		req_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("summary: %0d requests, %0d hits, %0d inserts, %0d full buckets, %0d clears",
			sb.requests, sb.hits, sb.inserts, sb.fulls, sb.clears);
		$display("summary: %0d mismatches, final unique count %0d", sb.errors, sb.entry_count);
		if (sb.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
